### src/tllt_pkg.sv
// Package for the two-lane lap timer: field widths, command codes, reset
// values and the transaction payload types. Depends on nothing.
package tllt_pkg;

  localparam int DEBOUNCE_W = 10;
  localparam int TS_W = 32;
  localparam int COUNT_W = 16;

  localparam int NUM_LANES_DEF = 2;
  localparam int TIME_BITS_DEF = 32;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic            cmd;
    logic            lane;
    logic [TS_W-1:0] now_ms;
  } tllt_item_t;

  typedef struct packed {
    logic               lane_out;
    logic               edge_accepted;
    logic               lap_completed;
    logic [TS_W-1:0]    lap_time_ms;
    logic [TS_W-1:0]    best_lap_ms;
    logic [COUNT_W-1:0] lap_total;
    logic               timing_active;
  } tllt_result_t;

endpackage

### src/tllt_ifs.sv
// Valid/ready channel interfaces for input events and result transactions.
// Depends on tllt_pkg for the payload types.
interface tllt_item_if import tllt_pkg::*; ();
  logic       valid;
  logic       ready;
  tllt_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tllt_result_if import tllt_pkg::*; ();
  logic         valid;
  logic         ready;
  tllt_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/tllt_update.sv
// Per-event update logic for one lane: debounce check, arming, lap closing
// and the result fields. Depends on tllt_pkg.
module tllt_update import tllt_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  cmd,
  input  logic                  lane,
  input  logic                  lane_ok,
  input  logic [TIME_BITS-1:0]  now_t,
  input  logic [DEBOUNCE_W-1:0] debounce,
  input  logic [TIME_BITS-1:0]  last_edge,
  input  logic [TIME_BITS-1:0]  lap_start,
  input  logic [TIME_BITS-1:0]  recent_lap,
  input  logic [TIME_BITS-1:0]  best_lap,
  input  logic [COUNT_W-1:0]    lap_count,
  input  logic                  armed,
  output logic                  accepted,
  output logic [TIME_BITS-1:0]  recent_lap_next,
  output logic [TIME_BITS-1:0]  best_lap_next,
  output logic [COUNT_W-1:0]    lap_count_next,
  output tllt_result_t          res
);

  logic [TIME_BITS-1:0] since;
  logic [TIME_BITS-1:0] lap;
  logic                 completed;
  logic                 show;

  assign since = now_t - last_edge;
  assign lap = now_t - lap_start;
  assign accepted = (cmd == CMD_EDGE) && lane_ok && (since > TIME_BITS'(debounce));
  assign completed = accepted && armed;

  assign recent_lap_next = completed ? lap : recent_lap;
  assign best_lap_next = (completed && ((lap < best_lap) || (best_lap == '0))) ? lap : best_lap;
  assign lap_count_next = (completed && (lap_count != COUNT_MAX)) ?
                          lap_count + COUNT_W'(1) : lap_count;

  // A clear command or a lane outside the array reports all lap values and flags as zero.
  assign show = (cmd == CMD_EDGE) && lane_ok;

  always_comb begin
    res.lane_out = lane;
    res.edge_accepted = accepted;
    res.lap_completed = completed;
    res.lap_time_ms = show ? TS_W'(recent_lap_next) : '0;
    res.best_lap_ms = show ? TS_W'(best_lap_next) : '0;
    res.lap_total = show ? lap_count_next : '0;
    res.timing_active = show && (armed || accepted);
  end

endmodule

### src/two_lane_lap_timer_top.sv
// Top level of the lap timer: input register, per-lane state, result register.
// Depends on tllt_pkg, tllt_ifs and tllt_update.
//
//  Channel   Direction  Handshake     Payload
//  item      in         valid/ready   cmd, lane, now_ms
//  result    out        valid/ready   lane_out, edge_accepted, lap_completed,
//                                     lap_time_ms, best_lap_ms, lap_total, timing_active
//  cfg       in         cfg_we        cfg_wdata (debounce_ms)
//
// Each event passes through the input register and then through the update logic
// into the result register.
// One event is accepted per cycle while the result side keeps up.
// A stalled result holds the update stage; the input register takes one more
// event only if it is empty. Reset restores the debounce time to 50 ms and clears all lane state.
module two_lane_lap_timer_top import tllt_pkg::*; #(
  parameter int NUM_LANES = NUM_LANES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tllt_item_if.sink             item,
  tllt_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [DEBOUNCE_W-1:0] cfg_wdata
);

  localparam int LANE_IW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

  logic [DEBOUNCE_W-1:0] debounce;

  logic                 s1_valid;
  tllt_item_t           s1;
  logic                 advance;
  logic                 fire;
  logic                 lane_ok;
  logic [LANE_IW-1:0]   idx;
  logic [TIME_BITS-1:0] now_t;

  logic [TIME_BITS-1:0] last_edge [NUM_LANES];
  logic [TIME_BITS-1:0] lap_start [NUM_LANES];
  logic [TIME_BITS-1:0] recent_lap [NUM_LANES];
  logic [TIME_BITS-1:0] best_lap [NUM_LANES];
  logic [COUNT_W-1:0]   lap_count [NUM_LANES];
  logic                 armed [NUM_LANES];

  logic                 accepted;
  logic [TIME_BITS-1:0] recent_lap_next;
  logic [TIME_BITS-1:0] best_lap_next;
  logic [COUNT_W-1:0]   lap_count_next;
  tllt_result_t         res_next;

  logic                 res_valid;
  tllt_result_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce <= cfg_wdata;
    end
  end

  assign advance = !res_valid || result.ready;
  assign item.ready = !s1_valid || advance;
  assign fire = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1 <= item.data;
    end
  end

  assign lane_ok = {31'b0, s1.lane} < NUM_LANES;
  assign idx = lane_ok ? LANE_IW'(s1.lane) : '0;
  assign now_t = TIME_BITS'(s1.now_ms);

  tllt_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .cmd             (s1.cmd),
    .lane            (s1.lane),
    .lane_ok         (lane_ok),
    .now_t           (now_t),
    .debounce        (debounce),
    .last_edge       (last_edge[idx]),
    .lap_start       (lap_start[idx]),
    .recent_lap      (recent_lap[idx]),
    .best_lap        (best_lap[idx]),
    .lap_count       (lap_count[idx]),
    .armed           (armed[idx]),
    .accepted        (accepted),
    .recent_lap_next (recent_lap_next),
    .best_lap_next   (best_lap_next),
    .lap_count_next  (lap_count_next),
    .res             (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        last_edge[l] <= '0;
        lap_start[l] <= '0;
        recent_lap[l] <= '0;
        best_lap[l] <= '0;
        lap_count[l] <= '0;
        armed[l] <= 1'b0;
      end
    end else if (fire && (s1.cmd == CMD_CLEAR)) begin
      // The last edge times survive a clear so debouncing stays continuous.
      for (int l = 0; l < NUM_LANES; l++) begin
        lap_start[l] <= '0;
        recent_lap[l] <= '0;
        best_lap[l] <= '0;
        lap_count[l] <= '0;
        armed[l] <= 1'b0;
      end
    end else if (fire && accepted) begin
      last_edge[idx] <= now_t;
      lap_start[idx] <= now_t;
      recent_lap[idx] <= recent_lap_next;
      best_lap[idx] <= best_lap_next;
      lap_count[idx] <= lap_count_next;
      armed[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.data = res;

endmodule

### src/tllt_checker.sv
// Port-level checks on the result channel of the lap timer, bound to the top.
// Depends on tllt_pkg and two_lane_lap_timer_top.
module tllt_checker import tllt_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         res_valid,
  input logic         res_ready,
  input tllt_result_t res_data
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result transaction valid right after reset.");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("Stalled result transaction changed.");

  a_lap_needs_edge: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.lap_completed |->
      res_data.edge_accepted && res_data.timing_active && (res_data.lap_total != '0))
    else $error("Completed lap without an accepted edge on an armed lane.");

  a_edge_arms: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.edge_accepted |-> res_data.timing_active)
    else $error("Accepted edge left the lane unarmed.");

  a_idle_lane_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.timing_active |->
      (res_data.lap_total == '0) && (res_data.lap_time_ms == '0) &&
      (res_data.best_lap_ms == '0))
    else $error("Unarmed lane reports lap values.");

endmodule

bind two_lane_lap_timer_top tllt_checker u_tllt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
